>>> src/ccl_pkg.sv
package ccl_pkg;

	localparam int VW = 6;
	localparam int CW = 7;
	localparam int MAX_VERTICES_DEF = 64;
	localparam logic [CW-1:0] VERTEX_COUNT_RST = CW'(64);

	localparam logic [1:0] CMD_EDGE  = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		ADJ_RD_IN,
		ADJ_RD_B,
		ADJ_RD_STACK,
		ADJ_RD_V
	} adj_rd_sel_t;

	typedef struct packed {
		logic        item_ready;
		logic        take_edge;
		logic        clear_adj;
		logic        run_init;
		adj_rd_sel_t adj_rd_sel;
		logic        adj_we;
		logic        adj_wr_b;
		logic        root_visit;
		logic        root_inc;
		logic        pop;
		logic        latch_v;
		logic        scan_step;
		logic        emit_start;
		logic        emit_load;
	} ccl_cmd_t;

	typedef struct packed {
		logic item_valid;
		logic item_edge_ok;
		logic item_run;
		logic item_clear;
		logic root_done;
		logic root_visited;
		logic depth_zero;
		logic scan_last;
		logic emit_last;
		logic out_free;
	} ccl_status_t;

endpackage

>>> src/ccl_if.sv
interface ccl_item_if import ccl_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [1:0]    cmd;
	logic [VW-1:0] edge_from;
	logic [VW-1:0] edge_to;

	modport source (output valid, output cmd, output edge_from, output edge_to, input ready);
	modport sink (input valid, input cmd, input edge_from, input edge_to, output ready);
endinterface

interface ccl_result_if import ccl_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [VW-1:0] vertex;
	logic [VW-1:0] component_label;
	logic          last;

	modport source (output valid, output vertex, output component_label, output last,
		input ready);
	modport sink (input valid, input vertex, input component_label, input last,
		output ready);
endinterface

>>> src/ccl_ram.sv
module ccl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/ccl_ctrl.sv
module ccl_ctrl import ccl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ccl_status_t st,
	output ccl_cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_EDGE_WA  = 9'b000000010,
		S_EDGE_WB  = 9'b000000100,
		S_ROOT     = 9'b000001000,
		S_POP      = 9'b000010000,
		S_POP_WAIT = 9'b000100000,
		S_SCAN     = 9'b001000000,
		S_EMIT_RD  = 9'b010000000,
		S_EMIT_WR  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.adj_rd_sel = ADJ_RD_IN;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.item_ready = 1'b1;
				if (st.item_valid) begin
					if (st.item_edge_ok) begin
						cmd.take_edge = 1'b1;
						state_d = S_EDGE_WA;
					end else if (st.item_clear) begin
						cmd.clear_adj = 1'b1;
					end else if (st.item_run) begin
						cmd.run_init = 1'b1;
						state_d = S_ROOT;
					end
				end
			end
			S_EDGE_WA: begin
				// write the first row while the second one is read
				cmd.adj_we = 1'b1;
				cmd.adj_rd_sel = ADJ_RD_B;
				state_d = S_EDGE_WB;
			end
			S_EDGE_WB: begin
				cmd.adj_we = 1'b1;
				cmd.adj_wr_b = 1'b1;
				state_d = S_IDLE;
			end
			S_ROOT: begin
				if (st.root_done) begin
					cmd.emit_start = 1'b1;
					state_d = S_EMIT_RD;
				end else if (st.root_visited) begin
					cmd.root_inc = 1'b1;
				end else begin
					cmd.root_visit = 1'b1;
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (st.depth_zero) begin
					cmd.root_inc = 1'b1;
					state_d = S_ROOT;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POP_WAIT;
				end
			end
			S_POP_WAIT: begin
				cmd.latch_v = 1'b1;
				cmd.adj_rd_sel = ADJ_RD_STACK;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.adj_rd_sel = ADJ_RD_V;
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					state_d = S_POP;
				end
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (st.out_free) begin
					cmd.emit_load = 1'b1;
					state_d = st.emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> src/ccl_dp.sv
module ccl_dp import ccl_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ccl_item_if.sink      items,
	ccl_result_if.source  results,
	input  logic          cfg_wr_en,
	input  logic [CW-1:0] cfg_wr_data,
	input  ccl_cmd_t      cmd,
	output ccl_status_t   st
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int DW = $clog2(MAX_VERTICES + 1);
	localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);
	localparam logic [MAX_VERTICES-1:0] ONE_HOT0 = MAX_VERTICES'(1);

	logic [CW-1:0]           vertex_count_q;
	logic [CW-1:0]           n;
	logic [CW-1:0]           n_m1;
	logic [AW-1:0]           a_q, b_q;
	logic [MAX_VERTICES-1:0] adj_valid_q;
	logic                    adj_rvalid_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [CW-1:0]           root_q;
	logic [DW-1:0]           depth_q;
	logic [DW-1:0]           depth_m1;
	logic [AW-1:0]           v_q, i_q, e_q;
	logic                    out_valid_q;
	logic [VW-1:0]           out_vertex_q;
	logic [VW-1:0]           out_label_q;
	logic                    out_last_q;

	logic [AW-1:0]           adj_raddr, adj_waddr, adj_other;
	logic [MAX_VERTICES-1:0] adj_rdata, adj_wdata, row;
	logic                    hit;
	logic                    stack_we, label_we;
	logic [AW-1:0]           stack_waddr, stack_wdata, stack_rdata;
	logic [AW-1:0]           label_waddr, label_rdata;

	assign n = (vertex_count_q > MAXV) ? MAXV : vertex_count_q;
	assign n_m1 = n - CW'(1);
	assign depth_m1 = depth_q - DW'(1);

	assign items.ready = cmd.item_ready;

	always_comb begin
		st = '0;
		st.item_valid = items.valid;
		st.item_edge_ok = (items.cmd == CMD_EDGE) && (CW'(items.edge_from) < n)
			&& (CW'(items.edge_to) < n);
		st.item_run = (items.cmd == CMD_RUN) && (n != '0);
		st.item_clear = (items.cmd == CMD_CLEAR);
		st.root_done = (root_q == n);
		st.root_visited = visited_q[root_q[AW-1:0]];
		st.depth_zero = (depth_q == '0);
		st.scan_last = (CW'(i_q) == n_m1);
		st.emit_last = (CW'(e_q) == n_m1);
		st.out_free = !out_valid_q || results.ready;
	end

	// adjacency rows; a row whose valid bit is low reads as empty
	always_comb begin
		case (cmd.adj_rd_sel)
			ADJ_RD_IN:    adj_raddr = items.edge_from[AW-1:0];
			ADJ_RD_B:     adj_raddr = b_q;
			ADJ_RD_STACK: adj_raddr = stack_rdata;
			ADJ_RD_V:     adj_raddr = v_q;
			default:      adj_raddr = v_q;
		endcase
	end

	assign row = adj_rvalid_q ? adj_rdata : '0;
	assign adj_waddr = cmd.adj_wr_b ? b_q : a_q;
	assign adj_other = cmd.adj_wr_b ? a_q : b_q;
	assign adj_wdata = row | (ONE_HOT0 << adj_other);

	ccl_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
		.clk   (clk),
		.we    (cmd.adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	assign hit = cmd.scan_step && row[i_q] && !visited_q[i_q];

	assign stack_we = cmd.root_visit || hit;
	assign stack_waddr = cmd.root_visit ? '0 : depth_q[AW-1:0];
	assign stack_wdata = cmd.root_visit ? root_q[AW-1:0] : i_q;

	ccl_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (stack_wdata),
		.raddr (depth_m1[AW-1:0]),
		.rdata (stack_rdata)
	);

	assign label_we = cmd.root_visit || hit;
	assign label_waddr = cmd.root_visit ? root_q[AW-1:0] : i_q;

	ccl_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_label_ram (
		.clk   (clk),
		.we    (label_we),
		.waddr (label_waddr),
		.wdata (root_q[AW-1:0]),
		.raddr (e_q),
		.rdata (label_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RST;
			adj_valid_q <= '0;
			visited_q <= '0;
			root_q <= '0;
			depth_q <= '0;
			i_q <= '0;
			e_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vertex_count_q <= cfg_wr_data;
			end
			if (cmd.clear_adj) begin
				adj_valid_q <= '0;
			end else if (cmd.adj_we) begin
				adj_valid_q[adj_waddr] <= 1'b1;
			end
			if (cmd.run_init) begin
				visited_q <= '0;
			end else if (cmd.root_visit) begin
				visited_q[root_q[AW-1:0]] <= 1'b1;
			end else if (hit) begin
				visited_q[i_q] <= 1'b1;
			end
			if (cmd.run_init) begin
				root_q <= '0;
			end else if (cmd.root_inc) begin
				root_q <= root_q + CW'(1);
			end
			if (cmd.run_init) begin
				depth_q <= '0;
			end else if (cmd.root_visit) begin
				depth_q <= DW'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_m1;
			end else if (hit) begin
				depth_q <= depth_q + DW'(1);
			end
			if (cmd.latch_v) begin
				i_q <= '0;
			end else if (cmd.scan_step) begin
				i_q <= i_q + AW'(1);
			end
			if (cmd.emit_start) begin
				e_q <= '0;
			end else if (cmd.emit_load) begin
				e_q <= e_q + AW'(1);
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		adj_rvalid_q <= adj_valid_q[adj_raddr];
		if (cmd.take_edge) begin
			a_q <= items.edge_from[AW-1:0];
			b_q <= items.edge_to[AW-1:0];
		end
		if (cmd.latch_v) begin
			v_q <= stack_rdata;
		end
		if (cmd.emit_load) begin
			out_vertex_q <= VW'(e_q);
			out_label_q <= VW'(label_rdata);
			out_last_q <= st.emit_last;
		end
	end

	assign results.valid = out_valid_q;
	assign results.vertex = out_vertex_q;
	assign results.component_label = out_label_q;
	assign results.last = out_last_q;

endmodule

>>> src/connected_component_labeler_core.sv
// Connected component labeller over an adjacency bit matrix of up to MAX_VERTICES vertices.
// items channel (valid/ready) carries one word per command: add an undirected edge
// (edge_from, edge_to), run the labelling, or clear the graph. Edges with an endpoint at
// or beyond the active vertex count are dropped; unused command codes are consumed silently.
// results channel (valid/ready) returns, for a run, one word per vertex in ascending order
// with the smallest vertex index of its component; last marks the final vertex.
// cfg_wr_en / cfg_wr_data write vertex_count; write it only while the block is idle.
// Operations:
//   edge: read-modify-write of both matrix rows through the one write port of the
//   matrix memory. run: each visited vertex has its adjacency row scanned one bit a
//   cycle, and each result is read through the label memory's registered read port.
// Reset empties the graph and sets vertex_count to 64; no clearing pass is needed, as the
// matrix rows carry valid bits. A stalled results receiver holds the current word in the
// output register and pauses the run; the block takes a new item once the last word of
// a run is in the output register.
module connected_component_labeler_core import ccl_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ccl_item_if.sink      items,
	ccl_result_if.source  results,
	input  logic          cfg_wr_en,
	input  logic [CW-1:0] cfg_wr_data
);

	ccl_cmd_t    cmd;
	ccl_status_t st;

	ccl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	ccl_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.items       (items),
		.results     (results),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.st          (st)
	);

`ifndef SYNTHESIS
	a_label_not_above_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.component_label <= results.vertex)
		else $error("component label above its vertex");

	a_busy_until_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.last |-> !items.ready)
		else $error("item taken before the run finished");

	a_run_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && st.item_run |=> !items.ready)
		else $error("run item did not start a sweep");
`endif

endmodule
